[src/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg: shared definitions for the calendar date subtract unit
// Field widths, unit and status codes, month length lookup and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

   // step count width; the week count holds up to seven times the count
   localparam int COUNT_WIDTH  = 10;
   localparam int NSTEP_WIDTH  = COUNT_WIDTH + 3;
   localparam int MULT_WIDTH   = 10;
   localparam int PROD_WIDTH   = COUNT_WIDTH + MULT_WIDTH;

   localparam int DAY_WIDTH    = 5;
   localparam int MONTH_WIDTH  = 4;
   localparam int YEAR_WIDTH   = 14;
   localparam int STATUS_WIDTH = 2;
   localparam int UNIT_WIDTH   = 3;
   localparam int CENT_WIDTH   = 8;
   localparam int REM_WIDTH    = 7;

   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = YEAR_WIDTH'(9999);

   // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact below 2**14
   localparam int RECIP_WIDTH = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_WIDTH-1:0] RECIP_100 = RECIP_WIDTH'(5243);
   localparam int CENT_PROD_WIDTH = YEAR_WIDTH + RECIP_WIDTH;
   localparam logic [REM_WIDTH-1:0] HUNDRED = REM_WIDTH'(100);
   localparam logic [REM_WIDTH-1:0] REM_TOP = REM_WIDTH'(99);

   // units
   localparam logic [UNIT_WIDTH-1:0] UNIT_DAY        = 3'd0;
   localparam logic [UNIT_WIDTH-1:0] UNIT_WEEK       = 3'd1;
   localparam logic [UNIT_WIDTH-1:0] UNIT_MONTH      = 3'd2;
   localparam logic [UNIT_WIDTH-1:0] UNIT_YEAR       = 3'd3;
   localparam logic [UNIT_WIDTH-1:0] UNIT_DECADE     = 3'd4;
   localparam logic [UNIT_WIDTH-1:0] UNIT_CENTURY    = 3'd5;
   localparam logic [UNIT_WIDTH-1:0] UNIT_MILLENNIUM = 3'd6;

   // result status
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_WIDTH-1:0]   DAY_LAST_DEC = 5'd31;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic calc_cent;
      logic calc_rem;
      logic mark_invalid;
      logic step_day;
      logic step_month;
      logic mul;
      logic sub;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                  date_ok;
      logic                  count_zero;
      logic                  failed;
      logic [UNIT_WIDTH-1:0] unit;
   } stat_type;

   // month length; zero for a month code outside 1..12
   function automatic logic [DAY_WIDTH-1:0] days_in(input logic [MONTH_WIDTH-1:0] month,
                                                    input logic leap);
      logic [DAY_WIDTH-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[src/cds_ctrl.sv]
// ----------------------------------------------------------------------------
// cds_ctrl: sequencing controller
// Walks one transaction through decode, date check, the stepping loop or
// the year multiply, and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cds_pkg::stat_type stat,
   output cds_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CENT  = 4'd1;
   localparam logic [3:0] S_REM   = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_DAY   = 4'd4;
   localparam logic [3:0] S_MONTH = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_SUB   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CENT;
            end
         end
         S_CENT: begin
            cmd.calc_cent = 1'b1;
            state_in      = S_REM;
         end
         S_REM: begin
            cmd.calc_rem = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (!stat.date_ok) begin
               cmd.mark_invalid = 1'b1;
               state_in         = S_DONE;
            end else begin
               case (stat.unit) inside
                  cds_pkg::UNIT_DAY, cds_pkg::UNIT_WEEK: state_in = S_DAY;
                  cds_pkg::UNIT_MONTH:                   state_in = S_MONTH;
                  cds_pkg::UNIT_YEAR, cds_pkg::UNIT_DECADE,
                  cds_pkg::UNIT_CENTURY, cds_pkg::UNIT_MILLENNIUM: state_in = S_MUL;
                  default:                               state_in = S_DONE;
               endcase
            end
         end
         S_DAY: begin
            if (stat.count_zero || stat.failed) begin
               state_in = S_DONE;
            end else begin
               cmd.step_day = 1'b1;
            end
         end
         S_MONTH: begin
            if (stat.count_zero || stat.failed) begin
               state_in = S_DONE;
            end else begin
               cmd.step_month = 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUB;
         end
         S_SUB: begin
            cmd.sub  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

`default_nettype wire

[src/cds_datapath.sv]
// ----------------------------------------------------------------------------
// cds_datapath: date registers and step logic
// Holds the working date with its year split into century and remainder
// for the leap test, the step counter, the year product and the status.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_datapath (
   input  wire logic                               clock,
   input  wire cds_pkg::cmd_type                   cmd,
   input  wire logic [cds_pkg::UNIT_WIDTH-1:0]     req_type,
   input  wire logic [cds_pkg::COUNT_WIDTH-1:0]    req_step_count,
   input  wire logic [cds_pkg::DAY_WIDTH-1:0]      req_start_day,
   input  wire logic [cds_pkg::MONTH_WIDTH-1:0]    req_start_month,
   input  wire logic [cds_pkg::YEAR_WIDTH-1:0]     req_start_year,
   output cds_pkg::stat_type                       stat,
   output logic [cds_pkg::DAY_WIDTH-1:0]           rsp_result_day,
   output logic [cds_pkg::MONTH_WIDTH-1:0]         rsp_result_month,
   output logic [cds_pkg::YEAR_WIDTH-1:0]          rsp_result_year,
   output logic [cds_pkg::STATUS_WIDTH-1:0]        rsp_status
);

   logic [cds_pkg::UNIT_WIDTH-1:0]   unit_ff;
   logic [cds_pkg::DAY_WIDTH-1:0]    orig_day_ff;
   logic [cds_pkg::MONTH_WIDTH-1:0]  orig_month_ff;
   logic [cds_pkg::YEAR_WIDTH-1:0]   orig_year_ff;
   logic [cds_pkg::DAY_WIDTH-1:0]    day_ff;
   logic [cds_pkg::MONTH_WIDTH-1:0]  month_ff;
   logic [cds_pkg::YEAR_WIDTH-1:0]   year_ff;
   logic [cds_pkg::CENT_WIDTH-1:0]   cent_ff;
   logic [cds_pkg::REM_WIDTH-1:0]    rem_ff;
   logic [cds_pkg::NSTEP_WIDTH-1:0]  nstep_ff;
   logic [cds_pkg::PROD_WIDTH-1:0]   prod_ff;
   logic [cds_pkg::STATUS_WIDTH-1:0] status_ff;

   logic [cds_pkg::NSTEP_WIDTH-1:0]     nstep_load;
   logic [cds_pkg::CENT_PROD_WIDTH-1:0] cent_prod;
   logic [cds_pkg::YEAR_WIDTH:0]        rem_full;
   logic                                leap;
   logic [cds_pkg::DAY_WIDTH-1:0]       cur_len;
   logic [cds_pkg::DAY_WIDTH-1:0]       prev_len;
   logic [cds_pkg::MONTH_WIDTH-1:0]     prev_month;
   logic [cds_pkg::MULT_WIDTH-1:0]      mult;
   logic                                at_year_start;

   // count in days for a week transaction
   assign nstep_load = (req_type == cds_pkg::UNIT_WEEK)
                     ? ({req_step_count, 3'b000} - cds_pkg::NSTEP_WIDTH'(req_step_count))
                     : cds_pkg::NSTEP_WIDTH'(req_step_count);

   // split the year: century by reciprocal multiply, then remainder
   assign cent_prod = year_ff * cds_pkg::RECIP_100;
   assign rem_full  = (cds_pkg::YEAR_WIDTH+1)'(year_ff)
                    - ((cds_pkg::YEAR_WIDTH+1)'(cent_ff)
                       * (cds_pkg::YEAR_WIDTH+1)'(cds_pkg::HUNDRED));

   // leap year from the split year
   assign leap = ((year_ff[1:0] == 2'b00) && (rem_ff != '0))
              || ((rem_ff == '0) && (cent_ff[1:0] == 2'b00));

   assign cur_len    = cds_pkg::days_in(month_ff, leap);
   assign prev_month = month_ff - 4'd1;
   assign prev_len   = cds_pkg::days_in(prev_month, leap);
   assign at_year_start = (month_ff == cds_pkg::MONTH_JAN);

   // years per unit
   always_comb begin
      case (unit_ff)
         cds_pkg::UNIT_DECADE:     mult = cds_pkg::MULT_WIDTH'(10);
         cds_pkg::UNIT_CENTURY:    mult = cds_pkg::MULT_WIDTH'(100);
         cds_pkg::UNIT_MILLENNIUM: mult = cds_pkg::MULT_WIDTH'(1000);
         default:                  mult = cds_pkg::MULT_WIDTH'(1);
      endcase
   end

   // update the working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         unit_ff       <= req_type;
         orig_day_ff   <= req_start_day;
         orig_month_ff <= req_start_month;
         orig_year_ff  <= req_start_year;
         day_ff        <= req_start_day;
         month_ff      <= req_start_month;
         year_ff       <= req_start_year;
         nstep_ff      <= nstep_load;
         status_ff     <= cds_pkg::STATUS_OK;
      end
      if (cmd.calc_cent) begin
         cent_ff <= cent_prod[cds_pkg::RECIP_SHIFT +: cds_pkg::CENT_WIDTH];
      end
      if (cmd.calc_rem) begin
         rem_ff <= rem_full[cds_pkg::REM_WIDTH-1:0];
      end
      if (cmd.mark_invalid) begin
         status_ff <= cds_pkg::STATUS_INVALID;
      end
      // one day back, borrowing across month and year ends
      if (cmd.step_day) begin
         nstep_ff <= nstep_ff - 1'b1;
         if (day_ff > 5'd1) begin
            day_ff <= day_ff - 5'd1;
         end else if (!at_year_start) begin
            month_ff <= prev_month;
            day_ff   <= prev_len;
         end else if (year_ff == '0) begin
            status_ff <= cds_pkg::STATUS_UNDERFLOW;
         end else begin
            month_ff <= cds_pkg::MONTH_DEC;
            day_ff   <= cds_pkg::DAY_LAST_DEC;
            year_ff  <= year_ff - 1'b1;
            if (rem_ff == '0) begin
               rem_ff  <= cds_pkg::REM_TOP;
               cent_ff <= cent_ff - 1'b1;
            end else begin
               rem_ff <= rem_ff - 1'b1;
            end
         end
      end
      // one month back, clamping the day to the new month
      if (cmd.step_month) begin
         nstep_ff <= nstep_ff - 1'b1;
         if (!at_year_start) begin
            month_ff <= prev_month;
            if (day_ff > prev_len) begin
               day_ff <= prev_len;
            end
         end else if (year_ff == '0) begin
            status_ff <= cds_pkg::STATUS_UNDERFLOW;
         end else begin
            // December always has 31 days: no clamp
            month_ff <= cds_pkg::MONTH_DEC;
            year_ff  <= year_ff - 1'b1;
            if (rem_ff == '0) begin
               rem_ff  <= cds_pkg::REM_TOP;
               cent_ff <= cent_ff - 1'b1;
            end else begin
               rem_ff <= rem_ff - 1'b1;
            end
         end
      end
      // year-based units: multiply, then subtract
      if (cmd.mul) begin
         prod_ff <= nstep_ff[cds_pkg::COUNT_WIDTH-1:0] * mult;
      end
      if (cmd.sub) begin
         if (prod_ff > cds_pkg::PROD_WIDTH'(year_ff)) begin
            status_ff <= cds_pkg::STATUS_UNDERFLOW;
         end else begin
            year_ff <= year_ff - prod_ff[cds_pkg::YEAR_WIDTH-1:0];
         end
      end
   end

   // status toward the controller
   always_comb begin
      stat            = '0;
      stat.date_ok    = (month_ff >= cds_pkg::MONTH_JAN) && (month_ff <= cds_pkg::MONTH_DEC)
                     && (year_ff <= cds_pkg::YEAR_MAX) && (day_ff != '0)
                     && (day_ff <= cur_len);
      stat.count_zero = (nstep_ff == '0);
      stat.failed     = (status_ff != cds_pkg::STATUS_OK);
      stat.unit       = unit_ff;
   end

   // echo the input date on any failure
   assign rsp_result_day   = stat.failed ? orig_day_ff   : day_ff;
   assign rsp_result_month = stat.failed ? orig_month_ff : month_ff;
   assign rsp_result_year  = stat.failed ? orig_year_ff  : year_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

[src/calendar_date_subtract_unit.sv]
// Month-free units (year to millennium) run the year multiply and subtract after the date check;
//   day, week and month run the stepping loop over days (count * 7 for a week) or months.
// The stepping loop moves one day or one month per cycle; worst case is a week
//   transaction of 7161 days.
// Throughput: one transaction at a time; start is taken again the cycle after the strobe.
// Reset is synchronous and returns the unit to idle; no result can be stalled.
// ----------------------------------------------------------------------------
// calendar_date_subtract_unit: Gregorian date decrement
// Moves a date back by a count of days, weeks, months, years, decades,
// centuries or millennia, flagging invalid input dates and year underflow.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_subtract_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [cds_pkg::UNIT_WIDTH-1:0]      req_type,
   input  wire logic [cds_pkg::COUNT_WIDTH-1:0]     req_step_count,
   input  wire logic [cds_pkg::DAY_WIDTH-1:0]       req_start_day,
   input  wire logic [cds_pkg::MONTH_WIDTH-1:0]     req_start_month,
   input  wire logic [cds_pkg::YEAR_WIDTH-1:0]      req_start_year,
   output logic                                     rsp_valid,
   output logic [cds_pkg::DAY_WIDTH-1:0]            rsp_result_day,
   output logic [cds_pkg::MONTH_WIDTH-1:0]          rsp_result_month,
   output logic [cds_pkg::YEAR_WIDTH-1:0]           rsp_result_year,
   output logic [cds_pkg::STATUS_WIDTH-1:0]         rsp_status
);

   cds_pkg::cmd_type  cmd;
   cds_pkg::stat_type stat;

   // sequencing
   cds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // date arithmetic
   cds_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_step_count   (req_step_count),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .stat             (stat),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

[src/cds_checker.sv]
// ----------------------------------------------------------------------------
// cds_checker: port-level checks
// Watches the command handshake and result strobe of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_valid,
   input wire logic [cds_pkg::STATUS_WIDTH-1:0]   rsp_status
);

   // an accepted transaction makes the unit busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("unit not busy after accepting a transaction");

   // a result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the strobe ends the transaction
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy ##1 !busy)
      else $error("unit still busy after result strobe");

   // status code is one of the defined ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == cds_pkg::STATUS_OK || rsp_status == cds_pkg::STATUS_INVALID
                     || rsp_status == cds_pkg::STATUS_UNDERFLOW))
      else $error("undefined result status");

endmodule

bind calendar_date_subtract_unit cds_checker u_cds_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);

`default_nettype wire

[sim/tb_calendar_date_subtract_unit.sv]
// ----------------------------------------------------------------------------
// tb_calendar_date_subtract_unit: self-checking bench for the date subtractor
// Sends dated transactions with a start/busy handshake and checks every
// strobed result against a behavioral date-stepping predictor. It covers
// directed corner dates and random mixes, with paced and back-to-back traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_subtract_unit;

   // Roughly 105 transactions at the worst-case week length plus sender gaps,
   // taken about four times over.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int IDLE_PERCENT = 22;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [cds_pkg::UNIT_WIDTH-1:0] UNIT_UNUSED = 3'd7;

   typedef struct packed {
      logic [cds_pkg::UNIT_WIDTH-1:0]  unit;
      logic [cds_pkg::COUNT_WIDTH-1:0] count;
      logic [cds_pkg::DAY_WIDTH-1:0]   day;
      logic [cds_pkg::MONTH_WIDTH-1:0] month;
      logic [cds_pkg::YEAR_WIDTH-1:0]  year;
   } date_request_type;

   typedef struct packed {
      logic [cds_pkg::DAY_WIDTH-1:0]    day;
      logic [cds_pkg::MONTH_WIDTH-1:0]  month;
      logic [cds_pkg::YEAR_WIDTH-1:0]   year;
      logic [cds_pkg::STATUS_WIDTH-1:0] status;
   } date_result_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [cds_pkg::UNIT_WIDTH-1:0]    req_type;
   logic [cds_pkg::COUNT_WIDTH-1:0]   req_step_count;
   logic [cds_pkg::DAY_WIDTH-1:0]     req_start_day;
   logic [cds_pkg::MONTH_WIDTH-1:0]   req_start_month;
   logic [cds_pkg::YEAR_WIDTH-1:0]    req_start_year;
   logic                              rsp_valid;
   logic [cds_pkg::DAY_WIDTH-1:0]     rsp_result_day;
   logic [cds_pkg::MONTH_WIDTH-1:0]   rsp_result_month;
   logic [cds_pkg::YEAR_WIDTH-1:0]    rsp_result_year;
   logic [cds_pkg::STATUS_WIDTH-1:0]  rsp_status;

   date_result_type dates_due[$];
   date_result_type oldest_due;
   int              error_count;
   int              sent_count;
   int              checked_count;
   bit              idle_enable;

   calendar_date_subtract_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_step_count   (req_step_count),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .rsp_valid        (rsp_valid),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Date predictor
   // ------------------------------------------------------------------
   function automatic bit is_leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_days(input int m, input int y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic date_result_type predict_date_back(input date_request_type rq);
      date_result_type                  r;
      int                               d, m, y, n, i, mult;
      logic [cds_pkg::STATUS_WIDTH-1:0] st;
      d  = int'(rq.day);
      m  = int'(rq.month);
      y  = int'(rq.year);
      st = cds_pkg::STATUS_OK;
      if (m < 1 || m > 12 || y > 9999 || d < 1 || d > month_days(m, y)) begin
         st = cds_pkg::STATUS_INVALID;
      end else if (rq.unit == cds_pkg::UNIT_DAY || rq.unit == cds_pkg::UNIT_WEEK) begin
         // walk back one day at a time, borrowing across month and year ends
         n = (rq.unit == cds_pkg::UNIT_DAY) ? int'(rq.count) : int'(rq.count) * 7;
         for (i = 0; i < n && st == cds_pkg::STATUS_OK; i++) begin
            if (d > 1) begin
               d--;
            end else if (m > 1) begin
               m--;
               d = month_days(m, y);
            end else begin
               m = 12;
               d = 31;
               y--;
               if (y < 0) st = cds_pkg::STATUS_UNDERFLOW;
            end
         end
      end else if (rq.unit == cds_pkg::UNIT_MONTH) begin
         // step back a month, clamping the day every step
         for (i = 0; i < int'(rq.count) && st == cds_pkg::STATUS_OK; i++) begin
            if (m > 1) begin
               m--;
            end else begin
               m = 12;
               y--;
               if (y < 0) st = cds_pkg::STATUS_UNDERFLOW;
            end
            if (st == cds_pkg::STATUS_OK && d > month_days(m, y)) d = month_days(m, y);
         end
      end else if (rq.unit >= cds_pkg::UNIT_YEAR && rq.unit <= cds_pkg::UNIT_MILLENNIUM) begin
         case (rq.unit)
            cds_pkg::UNIT_YEAR:    mult = 1;
            cds_pkg::UNIT_DECADE:  mult = 10;
            cds_pkg::UNIT_CENTURY: mult = 100;
            default:               mult = 1000;
         endcase
         y = int'(rq.year) - int'(rq.count) * mult;
         if (y < 0) st = cds_pkg::STATUS_UNDERFLOW;
      end
      // invalid or underflowed dates echo the input
      if (st != cds_pkg::STATUS_OK) begin
         d = int'(rq.day);
         m = int'(rq.month);
         y = int'(rq.year);
      end
      r.day    = d[cds_pkg::DAY_WIDTH-1:0];
      r.month  = m[cds_pkg::MONTH_WIDTH-1:0];
      r.year   = y[cds_pkg::YEAR_WIDTH-1:0];
      r.status = st;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking: compare each strobed result with the oldest due
   // ------------------------------------------------------------------
   task automatic report_field(input string label, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (dates_due.size() == 0) begin
            error_count++;
            $display("%0t: result with none due, expected nothing, actual %0d-%0d-%0d st %0d",
                     $time, rsp_result_year, rsp_result_month, rsp_result_day, rsp_status);
         end else begin
            oldest_due = dates_due.pop_front();
            checked_count++;
            report_field("day",    oldest_due.day,    rsp_result_day);
            report_field("month",  oldest_due.month,  rsp_result_month);
            report_field("year",   oldest_due.year,   rsp_result_year);
            report_field("status", oldest_due.status, rsp_status);
         end
      end
   end

   // Hard stop if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run exceeded %0d cycles, %0d results still due",
               $time, CYCLE_LIMIT, dates_due.size());
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers; all called at a falling edge
   // ------------------------------------------------------------------
   task automatic send_request(input date_request_type rq);
      int gap;
      if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         gap = $urandom_range(10, 1);
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_type        <= rq.unit;
      req_step_count  <= rq.count;
      req_start_day   <= rq.day;
      req_start_month <= rq.month;
      req_start_year  <= rq.year;
      // hold until the unit takes the transaction
      @(posedge clock);
      while (busy) @(posedge clock);
      dates_due.push_back(predict_date_back(rq));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_date(input logic [cds_pkg::UNIT_WIDTH-1:0] unit, input int count,
                            input int day, input int month, input int year);
      date_request_type rq;
      rq.unit  = unit;
      rq.count = count[cds_pkg::COUNT_WIDTH-1:0];
      rq.day   = day[cds_pkg::DAY_WIDTH-1:0];
      rq.month = month[cds_pkg::MONTH_WIDTH-1:0];
      rq.year  = year[cds_pkg::YEAR_WIDTH-1:0];
      send_request(rq);
   endtask

   // drop start and hold off until every result has come back
   task automatic wait_for_results();
      start <= 1'b0;
      while (dates_due.size() != 0) @(negedge clock);
   endtask

   function automatic date_request_type random_date_request();
      date_request_type rq;
      int y, m, d, mult;
      if ($urandom_range(99) < 15) begin
         // raw noise over the full field ranges
         rq.unit  = cds_pkg::UNIT_WIDTH'($urandom_range(7));
         rq.count = cds_pkg::COUNT_WIDTH'($urandom_range(1023));
         rq.day   = cds_pkg::DAY_WIDTH'($urandom_range(31));
         rq.month = cds_pkg::MONTH_WIDTH'($urandom_range(15));
         rq.year  = cds_pkg::YEAR_WIDTH'($urandom_range(16383));
         return rq;
      end
      y = ($urandom_range(99) < 30) ? $urandom_range(3) : $urandom_range(9999);
      m = $urandom_range(12, 1);
      d = ($urandom_range(9) == 0) ? month_days(m, y) : $urandom_range(month_days(m, y), 1);
      rq.unit  = cds_pkg::UNIT_WIDTH'($urandom_range(7));
      rq.day   = d[cds_pkg::DAY_WIDTH-1:0];
      rq.month = m[cds_pkg::MONTH_WIDTH-1:0];
      rq.year  = y[cds_pkg::YEAR_WIDTH-1:0];
      case (rq.unit)
         cds_pkg::UNIT_WEEK: rq.count = ($urandom_range(9) == 0)
                                      ? cds_pkg::COUNT_WIDTH'($urandom_range(1023))
                                      : cds_pkg::COUNT_WIDTH'($urandom_range(60));
         cds_pkg::UNIT_DECADE, cds_pkg::UNIT_CENTURY, cds_pkg::UNIT_MILLENNIUM: begin
            mult = (rq.unit == cds_pkg::UNIT_DECADE) ? 10
                 : (rq.unit == cds_pkg::UNIT_CENTURY) ? 100 : 1000;
            // mostly stay near the underflow boundary
            rq.count = ($urandom_range(99) < 30)
                     ? cds_pkg::COUNT_WIDTH'($urandom_range(1023))
                     : cds_pkg::COUNT_WIDTH'($urandom_range(y / mult + 1));
         end
         default:   rq.count = cds_pkg::COUNT_WIDTH'($urandom_range(1023));
      endcase
      return rq;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_dates();
      // zero count, single-day borrows and the longest day and week walks
      send_date(cds_pkg::UNIT_DAY, 0, 15, 6, 2020);
      send_date(cds_pkg::UNIT_DAY, 1, 1, 1, 2000);
      send_date(cds_pkg::UNIT_DAY, 1, 1, 3, 2000);
      send_date(cds_pkg::UNIT_DAY, 1, 1, 3, 1900);
      send_date(cds_pkg::UNIT_DAY, 1, 1, 3, 2023);
      send_date(cds_pkg::UNIT_DAY, 1, 1, 1, 0);
      send_date(cds_pkg::UNIT_DAY, 1023, 31, 12, 9999);
      send_date(cds_pkg::UNIT_WEEK, 1023, 31, 12, 9999);
      // month clamping, repeated at each step, and month underflow
      send_date(cds_pkg::UNIT_MONTH, 1, 31, 3, 2023);
      send_date(cds_pkg::UNIT_MONTH, 2, 31, 3, 2024);
      send_date(cds_pkg::UNIT_MONTH, 1, 15, 1, 0);
      // year-based units, boundaries and underflow
      send_date(cds_pkg::UNIT_YEAR, 1023, 31, 12, 9999);
      send_date(cds_pkg::UNIT_DECADE, 999, 1, 1, 9999);
      send_date(cds_pkg::UNIT_CENTURY, 99, 1, 1, 9999);
      send_date(cds_pkg::UNIT_MILLENNIUM, 9, 1, 1, 9999);
      send_date(cds_pkg::UNIT_MILLENNIUM, 1023, 1, 1, 9999);
      send_date(cds_pkg::UNIT_YEAR, 1, 29, 2, 2024);
      // unused unit
      send_date(UNIT_UNUSED, 5, 10, 10, 1000);
      // invalid dates
      send_date(UNIT_UNUSED, 1, 0, 5, 2000);
      send_date(cds_pkg::UNIT_DAY, 3, 1, 0, 2000);
      send_date(cds_pkg::UNIT_DAY, 3, 1, 15, 2000);
      send_date(cds_pkg::UNIT_DAY, 3, 31, 4, 2000);
      send_date(cds_pkg::UNIT_MONTH, 3, 29, 2, 2023);
      send_date(cds_pkg::UNIT_YEAR, 3, 1, 1, 10000);
      send_date(cds_pkg::UNIT_DAY, 1023, 31, 12, 16383);
   endtask

   task automatic test_random_paced(input int items);
      int k;
      idle_enable = 1'b1;
      for (k = 0; k < items; k++) send_request(random_date_request());
   endtask

   task automatic test_random_back_to_back(input int items);
      int k;
      idle_enable = 1'b0;
      for (k = 0; k < items; k++) send_request(random_date_request());
      idle_enable = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = '0;
      req_step_count  = '0;
      req_start_day   = '0;
      req_start_month = '0;
      req_start_year  = '0;
      error_count     = 0;
      sent_count      = 0;
      checked_count   = 0;
      idle_enable     = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_dates();
      wait_for_results();
      test_random_paced(60);
      wait_for_results();
      test_random_back_to_back(20);
      wait_for_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d date transactions: every unit, invalid dates, underflow,",
               sent_count);
      $display("paced and back-to-back traffic; %0d results checked, %0d errors",
               checked_count, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

[calendar_date_subtract_unit.f]
src/cds_pkg.sv
src/cds_ctrl.sv
src/cds_datapath.sv
src/calendar_date_subtract_unit.sv
src/cds_checker.sv
sim/tb_calendar_date_subtract_unit.sv
